// ----- src/rtprs_pkg.sv -----
// Shared types and constants for the RTP receive statistics unit.
package rtprs_pkg;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_MUL_HI  = 7'b0000010,
      ST_MUL_LO  = 7'b0000100,
      ST_JITTER  = 7'b0001000,
      ST_REPORT  = 7'b0010000,
      ST_DIVIDE  = 7'b0100000,
      ST_DELIVER = 7'b1000000
   } seq_state_type;

   localparam logic [1:0] ACT_PACKET = 2'd0;
   localparam logic [1:0] ACT_SENDER = 2'd1;
   localparam logic [1:0] ACT_REPORT = 2'd2;

   localparam logic [19:0] CLOCK_RATE_RESET = 20'd90000;
   localparam logic [23:0] LOST_MAX = 24'hFFFFFF;
   localparam logic [7:0]  FRACTION_MAX = 8'd255;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- src/rtprs_div.sv -----
// Restoring divider giving an 8-bit fraction, one quotient bit per cycle.
module rtprs_div
   import rtprs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [32:0]    dividend,
   input  logic [32:0]    divisor,
   output logic [7:0]     quotient,
   output div_status_type status
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [7:0]  quo_ff, quo_in;
   logic [33:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff[32:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         rem_in  = {1'b0, dividend};
         dvs_in  = divisor;
         quo_in  = 8'd0;
      end else if (busy_ff) begin
         // subtract when the doubled remainder reaches the divisor
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- src/rtp_receive_statistics_unit.sv -----
// RTP receive statistics for one remote stream, producing RTCP report blocks.
//
// A packet beat makes two passes through the shared 32x20 multiplier that turns
// NTP arrival time into RTP ticks, then updates transit and jitter; a sender
// report beat is handled in the idle state; a report beat computes the block and,
// when the loss fraction needs it, waits for the bit-serial divider. The block
// takes no new beat while it works on one, but it accepts the next beat while
// a finished report still waits at the output register. Beats with an
// unused action code are dropped. clock_rate may only be written while idle.
module rtp_receive_statistics_unit
   import rtprs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [19:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_ssrc,
   input  logic [15:0] req_seq,
   input  logic [31:0] req_rtp_ts,
   input  logic [63:0] req_ntp_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_block_valid,
   output logic [31:0] rsp_reported_ssrc,
   output logic [7:0]  rsp_fraction_lost,
   output logic [23:0] rsp_cumulative_lost,
   output logic [31:0] rsp_ext_highest_seq,
   output logic [31:0] rsp_jitter_ticks,
   output logic [31:0] rsp_lsr,
   output logic [31:0] rsp_dlsr
);

   seq_state_type state_ff, state_in;

   logic [19:0] clock_rate_ff, clock_rate_in;
   logic        active_ff, active_in;
   logic [31:0] ssrc_ff, ssrc_in;
   logic [15:0] base_ff, base_in;
   logic [15:0] max_ff, max_in;
   logic [15:0] wrap_ff, wrap_in;
   logic [31:0] received_ff, received_in;
   logic [31:0] exp_prior_ff, exp_prior_in;
   logic [31:0] rec_prior_ff, rec_prior_in;
   logic [31:0] last_transit_ff, last_transit_in;
   logic [35:0] jitter_ff, jitter_in;
   logic [63:0] last_sr_ff, last_sr_in;
   logic        sr_seen_ff, sr_seen_in;

   // working registers of one beat
   logic [31:0] rtp_ts_ff, rtp_ts_in;
   logic [63:0] ntp_ff, ntp_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] expected_ff, expected_in;
   logic        blk_ff, blk_in;
   logic [7:0]  fraction_ff, fraction_in;
   logic [23:0] lost_ff, lost_in;
   logic [31:0] lsr_ff, lsr_in;
   logic [31:0] dlsr_ff, dlsr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        o_blk_ff, o_blk_in;
   logic [31:0] o_ssrc_ff, o_ssrc_in;
   logic [7:0]  o_frac_ff, o_frac_in;
   logic [23:0] o_lost_ff, o_lost_in;
   logic [31:0] o_ext_ff, o_ext_in;
   logic [31:0] o_jit_ff, o_jit_in;
   logic [31:0] o_lsr_ff, o_lsr_in;
   logic [31:0] o_dlsr_ff, o_dlsr_in;

   logic        accept;
   logic [31:0] mul_a;
   logic [51:0] product;
   logic [15:0] d_max, d_base;
   logic [31:0] transit, dd;
   logic [36:0] jit_round;
   logic [32:0] lost_w, exp_int;
   logic [31:0] rec_int;
   logic [33:0] lost_int;
   logic [63:0] since_sr;
   logic        div_start;
   logic [32:0] div_dividend, div_divisor;
   logic [7:0]  quotient;
   div_status_type div_status;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // shared multiplier: high then low word of the NTP time
   assign mul_a   = (state_ff == ST_MUL_HI) ? ntp_ff[63:32] : ntp_ff[31:0];
   assign product = {20'd0, mul_a} * {32'd0, clock_rate_ff};

   assign d_max  = req_seq - max_ff;
   assign d_base = req_seq - base_ff;

   assign transit   = acc_ff + {12'd0, product[51:32]} - rtp_ts_ff;
   assign dd        = transit - last_transit_ff;
   // keep the rounding carry out of the top jitter bit
   assign jit_round = {1'b0, jitter_ff} + 37'd8;
   assign lost_w    = {1'b0, expected_ff} - {1'b0, received_ff};
   assign exp_int   = {1'b0, expected_ff} - {1'b0, exp_prior_ff};
   assign rec_int   = received_ff - rec_prior_ff;
   assign lost_int  = {exp_int[32], exp_int} - {2'b00, rec_int};
   assign since_sr  = ntp_ff - last_sr_ff;

   assign div_dividend = lost_int[32:0];
   assign div_divisor  = exp_int;

   rtprs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .status   (div_status)
   );

   always_comb begin
      state_in        = state_ff;
      clock_rate_in   = csr_write_en ? csr_write_data : clock_rate_ff;
      active_in       = active_ff;
      ssrc_in         = ssrc_ff;
      base_in         = base_ff;
      max_in          = max_ff;
      wrap_in         = wrap_ff;
      received_in     = received_ff;
      exp_prior_in    = exp_prior_ff;
      rec_prior_in    = rec_prior_ff;
      last_transit_in = last_transit_ff;
      jitter_in       = jitter_ff;
      last_sr_in      = last_sr_ff;
      sr_seen_in      = sr_seen_ff;
      rtp_ts_in       = rtp_ts_ff;
      ntp_in          = ntp_ff;
      acc_in          = acc_ff;
      mag_in          = mag_ff;
      expected_in     = expected_ff;
      blk_in          = blk_ff;
      fraction_in     = fraction_ff;
      lost_in         = lost_ff;
      lsr_in          = lsr_ff;
      dlsr_in         = dlsr_ff;
      div_start       = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      o_blk_in        = o_blk_ff;
      o_ssrc_in       = o_ssrc_ff;
      o_frac_in       = o_frac_ff;
      o_lost_in       = o_lost_ff;
      o_ext_in        = o_ext_ff;
      o_jit_in        = o_jit_ff;
      o_lsr_in        = o_lsr_ff;
      o_dlsr_in       = o_dlsr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rtp_ts_in = req_rtp_ts;
               ntp_in    = req_ntp_time;
               case (req_action)
                  ACT_PACKET: begin
                     if (!active_ff) begin
                        active_in   = 1'b1;
                        ssrc_in     = req_ssrc;
                        base_in     = req_seq;
                        max_in      = req_seq;
                        wrap_in     = 16'd0;
                        received_in = received_ff + 32'd1;
                        state_in    = ST_MUL_HI;
                     end else if (req_ssrc == ssrc_ff) begin
                        if (d_max != 16'd0 && !d_max[15]) begin
                           if (req_seq < max_ff) begin
                              wrap_in = wrap_ff + 16'd1;
                           end
                           max_in = req_seq;
                        end else if (d_base[15]) begin
                           base_in = req_seq;
                        end
                        received_in = received_ff + 32'd1;
                        state_in    = ST_MUL_HI;
                     end
                  end
                  ACT_SENDER: begin
                     if (active_ff && req_ssrc == ssrc_ff) begin
                        last_sr_in = req_ntp_time;
                        sr_seen_in = 1'b1;
                     end
                  end
                  ACT_REPORT: begin
                     blk_in      = active_ff;
                     expected_in = {wrap_ff, max_ff} - {16'd0, base_ff} + 32'd1;
                     state_in    = active_ff ? ST_REPORT : ST_DELIVER;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL_HI: begin
            acc_in   = product[31:0];
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mag_in          = dd[31] ? (~dd + 32'd1) : dd;
            last_transit_in = transit;
            state_in        = ST_JITTER;
         end
         ST_JITTER: begin
            jitter_in = jitter_ff + {4'd0, mag_ff} - {3'd0, jit_round[36:4]};
            state_in  = ST_IDLE;
         end
         ST_REPORT: begin
            if (lost_w[32]) begin
               lost_in = 24'd0;
            end else if (lost_w[31:24] != 8'd0) begin
               lost_in = LOST_MAX;
            end else begin
               lost_in = lost_w[23:0];
            end
            lsr_in       = sr_seen_ff ? last_sr_ff[47:16] : 32'd0;
            dlsr_in      = sr_seen_ff ? since_sr[47:16] : 32'd0;
            exp_prior_in = expected_ff;
            rec_prior_in = received_ff;
            fraction_in  = 8'd0;
            state_in     = ST_DELIVER;
            if (!exp_int[32] && exp_int != 33'd0 && !lost_int[33] && lost_int != 34'd0) begin
               if (lost_int[32:0] >= exp_int) begin
                  fraction_in = FRACTION_MAX;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               fraction_in = quotient;
               state_in    = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_blk_in     = blk_ff;
               o_ssrc_in    = blk_ff ? ssrc_ff : 32'd0;
               o_frac_in    = blk_ff ? fraction_ff : 8'd0;
               o_lost_in    = blk_ff ? lost_ff : 24'd0;
               o_ext_in     = blk_ff ? {wrap_ff, max_ff} : 32'd0;
               o_jit_in     = blk_ff ? jitter_ff[35:4] : 32'd0;
               o_lsr_in     = blk_ff ? lsr_ff : 32'd0;
               o_dlsr_in    = blk_ff ? dlsr_ff : 32'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         clock_rate_ff   <= CLOCK_RATE_RESET;
         active_ff       <= 1'b0;
         ssrc_ff         <= 32'd0;
         base_ff         <= 16'd0;
         max_ff          <= 16'd0;
         wrap_ff         <= 16'd0;
         received_ff     <= 32'd0;
         exp_prior_ff    <= 32'd0;
         rec_prior_ff    <= 32'd0;
         last_transit_ff <= 32'd0;
         jitter_ff       <= 36'd0;
         last_sr_ff      <= 64'd0;
         sr_seen_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clock_rate_ff   <= clock_rate_in;
         active_ff       <= active_in;
         ssrc_ff         <= ssrc_in;
         base_ff         <= base_in;
         max_ff          <= max_in;
         wrap_ff         <= wrap_in;
         received_ff     <= received_in;
         exp_prior_ff    <= exp_prior_in;
         rec_prior_ff    <= rec_prior_in;
         last_transit_ff <= last_transit_in;
         jitter_ff       <= jitter_in;
         last_sr_ff      <= last_sr_in;
         sr_seen_ff      <= sr_seen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rtp_ts_ff   <= rtp_ts_in;
      ntp_ff      <= ntp_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      expected_ff <= expected_in;
      blk_ff      <= blk_in;
      fraction_ff <= fraction_in;
      lost_ff     <= lost_in;
      lsr_ff      <= lsr_in;
      dlsr_ff     <= dlsr_in;
      o_blk_ff    <= o_blk_in;
      o_ssrc_ff   <= o_ssrc_in;
      o_frac_ff   <= o_frac_in;
      o_lost_ff   <= o_lost_in;
      o_ext_ff    <= o_ext_in;
      o_jit_ff    <= o_jit_in;
      o_lsr_ff    <= o_lsr_in;
      o_dlsr_ff   <= o_dlsr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_block_valid     = o_blk_ff;
   assign rsp_reported_ssrc   = o_ssrc_ff;
   assign rsp_fraction_lost   = o_frac_ff;
   assign rsp_cumulative_lost = o_lost_ff;
   assign rsp_ext_highest_seq = o_ext_ff;
   assign rsp_jitter_ticks    = o_jit_ff;
   assign rsp_lsr             = o_lsr_ff;
   assign rsp_dlsr            = o_dlsr_ff;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the RTP receive statistics unit.
`timescale 1ns / 100ps

module testbench;
   import rtprs_pkg::*;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] ssrc;
      logic [15:0] seq;
      logic [31:0] rtp_ts;
      logic [63:0] ntp_time;
   } event_type;

   typedef struct packed {
      logic        block_valid;
      logic [31:0] reported_ssrc;
      logic [7:0]  fraction_lost;
      logic [23:0] cumulative_lost;
      logic [31:0] ext_highest_seq;
      logic [31:0] jitter_ticks;
      logic [31:0] lsr;
      logic [31:0] dlsr;
   } block_type;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [19:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [31:0] req_ssrc = '0;
   logic [15:0] req_seq = '0;
   logic [31:0] req_rtp_ts = '0;
   logic [63:0] req_ntp_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   block_type   rsp;

   rtp_receive_statistics_unit dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_ssrc(req_ssrc), .req_seq(req_seq), .req_rtp_ts(req_rtp_ts),
      .req_ntp_time(req_ntp_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_block_valid(rsp.block_valid), .rsp_reported_ssrc(rsp.reported_ssrc),
      .rsp_fraction_lost(rsp.fraction_lost), .rsp_cumulative_lost(rsp.cumulative_lost),
      .rsp_ext_highest_seq(rsp.ext_highest_seq), .rsp_jitter_ticks(rsp.jitter_ticks),
      .rsp_lsr(rsp.lsr), .rsp_dlsr(rsp.dlsr)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the stream statistics
   logic [19:0] rate_q;
   logic        active_q, sr_seen_q;
   logic [31:0] ssrc_q, rcv_q, exp_prior_q, rcv_prior_q, transit_q;
   logic [15:0] base_q, max_q, wraps_q;
   logic [35:0] jitter_q;
   logic [63:0] sr_time_q;

   event_type   pending_events[$];
   block_type   expected_blocks[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0, gap_left = 0;
   logic        traffic_done = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void clear_stats();
      active_q = 0; sr_seen_q = 0; ssrc_q = 0; rcv_q = 0; exp_prior_q = 0;
      rcv_prior_q = 0; transit_q = 0; base_q = 0; max_q = 0; wraps_q = 0;
      jitter_q = 0; sr_time_q = 0;
   endfunction

   function automatic void track_packet(event_type ev);
      logic [83:0] prod;
      logic [31:0] transit, dd, mag;
      logic [15:0] dmax, dbase;
      if (!active_q) begin
         ssrc_q = ev.ssrc; base_q = ev.seq; max_q = ev.seq; wraps_q = 0;
         active_q = 1;
      end else if (ev.ssrc != ssrc_q) begin
         return;
      end
      dmax = ev.seq - max_q;
      dbase = ev.seq - base_q;
      if (dmax != 0 && !dmax[15]) begin
         if (ev.seq < max_q) wraps_q = wraps_q + 1;
         max_q = ev.seq;
      end else if (dbase[15]) begin
         base_q = ev.seq;
      end
      rcv_q = rcv_q + 1;
      prod = ev.ntp_time * rate_q;
      transit = prod[63:32] - ev.rtp_ts;
      dd = transit - transit_q;
      mag = dd[31] ? -dd : dd;
      jitter_q = 36'(jitter_q + mag - ((37'(jitter_q) + 37'd8) >> 4));
      transit_q = transit;
   endfunction

   function automatic block_type build_block(logic [63:0] now);
      block_type b;
      logic [31:0] ext_max, expected;
      longint lost, exp_int, lost_int;
      logic [63:0] age;
      b = '0;
      if (!active_q) return b;
      ext_max = {wraps_q, 16'h0} + max_q;
      expected = ext_max - base_q + 1;
      lost = longint'(expected) - longint'(rcv_q);
      if (lost < 0) lost = 0;
      if (lost > 64'hFFFFFF) lost = 64'hFFFFFF;
      exp_int = longint'(expected) - longint'(exp_prior_q);
      lost_int = exp_int - longint'(rcv_q - rcv_prior_q);
      if (exp_int > 0 && lost_int > 0)
         b.fraction_lost = (lost_int >= exp_int) ? 8'd255 : 8'((lost_int * 256) / exp_int);
      exp_prior_q = expected;
      rcv_prior_q = rcv_q;
      b.block_valid = 1;
      b.reported_ssrc = ssrc_q;
      b.cumulative_lost = lost[23:0];
      b.ext_highest_seq = ext_max;
      b.jitter_ticks = jitter_q[35:4];
      if (sr_seen_q) begin
         age = now - sr_time_q;
         b.lsr = sr_time_q[47:16];
         b.dlsr = age[47:16];
      end
      return b;
   endfunction

   function automatic void predict(event_type ev);
      case (ev.action)
         ACT_PACKET: track_packet(ev);
         ACT_SENDER: if (active_q && ev.ssrc == ssrc_q) begin
            sr_time_q = ev.ntp_time; sr_seen_q = 1;
         end
         ACT_REPORT: expected_blocks.push_back(build_block(ev.ntp_time));
         default: ;
      endcase
   endfunction

   function automatic event_type make_event(logic [1:0] act, logic [31:0] ssrc,
                                           logic [15:0] seq, logic [31:0] ts,
                                           logic [63:0] ntp);
      event_type ev;
      ev.action = act; ev.ssrc = ssrc; ev.seq = seq; ev.rtp_ts = ts; ev.ntp_time = ntp;
      return ev;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // driver: bursts of beats with random gaps
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && !(req_valid && req_stall)) begin
         if (req_valid) predict({req_action, req_ssrc, req_seq, req_rtp_ts, req_ntp_time});
         if (gap_left > 0 || pending_events.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            event_type ev;
            ev = pending_events.pop_front();
            req_valid <= 1'b1;
            req_action <= ev.action; req_ssrc <= ev.ssrc; req_seq <= ev.seq;
            req_rtp_ts <= ev.rtp_ts; req_ntp_time <= ev.ntp_time;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(12, 1);
               gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 0);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // monitor: stall on its own pattern, check each beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected block", 0, 0);
            end else begin
               block_type w;
               w = expected_blocks.pop_front();
               if (rsp.block_valid != w.block_valid)
                  report_mismatch("block_valid", rsp.block_valid, w.block_valid);
               if (rsp.reported_ssrc != w.reported_ssrc)
                  report_mismatch("reported_ssrc", rsp.reported_ssrc, w.reported_ssrc);
               if (rsp.fraction_lost != w.fraction_lost)
                  report_mismatch("fraction_lost", rsp.fraction_lost, w.fraction_lost);
               if (rsp.cumulative_lost != w.cumulative_lost)
                  report_mismatch("cumulative_lost", rsp.cumulative_lost, w.cumulative_lost);
               if (rsp.ext_highest_seq != w.ext_highest_seq)
                  report_mismatch("ext_highest_seq", rsp.ext_highest_seq, w.ext_highest_seq);
               if (rsp.jitter_ticks != w.jitter_ticks)
                  report_mismatch("jitter_ticks", rsp.jitter_ticks, w.jitter_ticks);
               if (rsp.lsr != w.lsr) report_mismatch("lsr", rsp.lsr, w.lsr);
               if (rsp.dlsr != w.dlsr) report_mismatch("dlsr", rsp.dlsr, w.dlsr);
            end
         end
         rsp_stall <= (cycle_count % 512 < 128) ? 1'b0 : ($urandom_range(2, 0) == 0);
      end
   end

   task automatic wait_idle();
      while (pending_events.size() != 0 || req_valid || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_rate(logic [19:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      rate_q = value;
   endtask

   // a well-formed stream: mostly in order, some loss, reorder and wrap
   task automatic queue_stream(int count, logic [31:0] ssrc);
      logic [15:0] seq;
      logic [31:0] ts;
      logic [63:0] ntp;
      int r;
      seq = 16'($urandom); ts = $urandom; ntp = rand64();
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99, 0);
         ntp = ntp + {$urandom_range(3, 0), $urandom};
         ts = ts + $urandom_range(6000, 0);
         if (r < 70) seq = seq + 16'd1;
         else if (r < 80) seq = seq + 16'($urandom_range(5, 2));
         else if (r < 85) seq = seq - 16'($urandom_range(4, 1));
         else if (r < 87) seq = 16'($urandom);
         if (r < 8)
            pending_events.push_back(make_event(ACT_REPORT, $urandom, 16'($urandom),
                                                $urandom, ntp));
         else if (r < 12)
            pending_events.push_back(make_event(ACT_SENDER, ssrc, 16'($urandom),
                                                $urandom, ntp));
         else if (r < 14)
            pending_events.push_back(make_event(2'($urandom_range(3, 0)), $urandom,
                                                16'($urandom), $urandom, rand64()));
         else
            pending_events.push_back(make_event(ACT_PACKET, ssrc, seq, ts, ntp));
      end
   endtask

   initial begin
      rate_q = CLOCK_RATE_RESET;
      clear_stats();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: inactive report, early SR, unused action, field extremes
      pending_events.push_back(make_event(ACT_REPORT, '1, '1, '1, '1));
      pending_events.push_back(make_event(ACT_SENDER, 0, 0, 0, 64'h1234_5678_9abc_def0));
      pending_events.push_back(make_event(2'd3, '1, '1, '1, '1));
      pending_events.push_back(make_event(ACT_PACKET, 32'hffff_ffff, 16'hfffe, '1, '1));
      pending_events.push_back(make_event(ACT_PACKET, 32'h0, 16'h0005, 0, 0));
      pending_events.push_back(make_event(ACT_PACKET, 32'hffff_ffff, 16'h0003, 0, 0));
      pending_events.push_back(make_event(ACT_PACKET, 32'hffff_ffff, 16'hfff0, 0, '1));
      pending_events.push_back(make_event(ACT_REPORT, 0, 0, 0, 0));
      pending_events.push_back(make_event(ACT_SENDER, 32'h0, 0, 0, 64'hffff_0000_0000_ffff));
      pending_events.push_back(make_event(ACT_SENDER, 32'hffff_ffff, 0, 0,
                                          64'h8000_1234_5678_0000));
      pending_events.push_back(make_event(ACT_PACKET, 32'hffff_ffff, 16'h0004, 32'h8000_0000,
                                          64'h0000_0001_0000_0000));
      pending_events.push_back(make_event(ACT_REPORT, 0, 0, 0, '1));
      pending_events.push_back(make_event(ACT_REPORT, 0, 0, 0, 0));
      pending_events.push_back(make_event(ACT_PACKET, 32'hffff_ffff, 16'h0004, 0, 0));
      pending_events.push_back(make_event(ACT_REPORT, 0, 0, 0, 64'h8000_0000_0000_0000));
      wait_idle();

      // random phases with several clock rates, each queueing a stream with a new random SSRC
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_rate(20'd1);
            1: write_rate(20'd1000000);
            2: write_rate(20'hFFFFF);
            3: write_rate(20'd8000);
            default: write_rate(20'($urandom_range(1000000, 1)));
         endcase
         queue_stream(300, $urandom);
         wait_idle();
      end
      traffic_done = 1'b1;
   end

   initial begin
      wait (traffic_done || cycle_count >= CYCLE_LIMIT);
      if (!traffic_done) begin
         $display("CHECKS FAILED");
      end else if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
